// ----- rtl/core/skgc_pkg.sv -----
// Shared widths, register codes, reset values and the log2 fraction table function.
package skgc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int DB_SCALE_BITS = 19;
    // 20 / log2(10) in Q16
    localparam logic [DB_SCALE_BITS-1:0] DB_SCALE_Q16 = 19'd394566;

    // dB magnitude after the -100 dB clamp
    localparam int DB_W = 15;
    localparam logic [DB_W-1:0] DB_FLOOR_MAG = 15'd25600;

    localparam int THR_W     = 15;
    localparam int SLOPE_W   = 16;
    localparam int KNEE_W    = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int GAIN_W    = 16;

    localparam logic [THR_W-1:0]   THR_RESET   = 15'h6C00;  // -20 dB
    localparam logic [SLOPE_W-1:0] SLOPE_RESET = 16'hC000;  // -0.5
    localparam logic [KNEE_W-1:0]  KNEE_RESET  = 13'd1536;  // 6 dB

    // Gain datapath widths
    localparam int OPA_W   = 15;  // knee term or overshoot
    localparam int SQ_W    = 28;  // squared knee term
    localparam int GPROD_W = 44;  // slope magnitude times SQ
    localparam int NUM_W   = 26;  // rounded dividend for the knee region
    localparam int QUO_W   = 13;  // knee quotient, at most 4096
    localparam int LIN_W   = 15;  // linear-region gain magnitude, at most 16384

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SLOPE     = 2'd1,
        CFG_KNEE      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             last;
        logic             zero;
        logic             knee;
        logic             neg;
        logic [LIN_W-1:0] lin_q;
    } t_gain_side;

    // log2(1 + idx / 2^tbits) in Q.16 by repeated squaring of a Q1.30 value
    function automatic logic [FRAC_BITS-1:0] log_frac(input int unsigned idx,
                                                      input int unsigned tbits);
        logic [63:0]          x;
        logic [FRAC_BITS-1:0] r;
        x = (64'd1 << 30) + (64'(idx) << (30 - tbits));
        r = '0;
        for (int k = FRAC_BITS - 1; k >= 0; k--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x    = x >> 1;
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/skgc_log.sv -----
// Level detector: sample magnitude, floor, fixed-length log2 and dB conversion in six stages.
module skgc_log #(
    parameter int SAMPLE_BITS    = 24,
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic                         i_last,
    output logic                         o_valid,
    output logic [skgc_pkg::DB_W-1:0]    o_db,
    output logic                         o_last
);
    import skgc_pkg::*;

    localparam int LZ_W   = $clog2(SAMPLE_BITS);
    localparam int NEG_W  = LZ_W + FRAC_BITS;
    localparam int PROD_W = NEG_W + DB_SCALE_BITS;
    localparam int U_W    = PROD_W - 23;
    localparam int TAB_N  = 1 << LOG_TABLE_BITS;

    localparam longint unsigned FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);
    localparam longint unsigned FLOOR_RAW  = (FULL_SCALE + 64'd500000) / 64'd1000000;
    localparam logic [SAMPLE_BITS-1:0] MAG_FLOOR =
        (FLOOR_RAW < 64'd1) ? SAMPLE_BITS'(1) : SAMPLE_BITS'(FLOOR_RAW);
    localparam logic [PROD_W:0] ROUND_ADD = (PROD_W + 1)'(1) << 23;

    // Fraction table, built at elaboration
    logic [FRAC_BITS-1:0] w_frac_tab [TAB_N];
    for (genvar g = 0; g < TAB_N; g++) begin : g_tab
        localparam logic [FRAC_BITS-1:0] FRAC_VAL = log_frac(g, LOG_TABLE_BITS);
        assign w_frac_tab[g] = FRAC_VAL;
    end

    logic                      r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    logic                      r_s1_last, r_s2_last, r_s3_last, r_s4_last, r_s5_last, r_s6_last;
    logic [SAMPLE_BITS-1:0]    r_s1_mag, r_s2_mag;
    logic [LZ_W-1:0]           r_s2_lz, r_s3_lz;
    logic [LOG_TABLE_BITS-1:0] r_s3_idx;
    logic [NEG_W-1:0]          r_s4_neg;
    logic [PROD_W-1:0]         r_s5_prod;
    logic [DB_W-1:0]           r_s6_db;

    logic [SAMPLE_BITS-1:0]    n_mag;
    logic [LZ_W-1:0]           w_pos;
    logic [LZ_W-1:0]           n_lz;
    logic [SAMPLE_BITS-1:0]    w_norm;
    logic [NEG_W-1:0]          n_neg;
    logic [PROD_W:0]           w_round;
    logic [U_W-1:0]            w_u;
    logic [DB_W-1:0]           n_db;

    always_comb begin
        n_mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;
        if (n_mag < MAG_FLOOR) begin
            n_mag = MAG_FLOOR;
        end
    end

    // Leading one position; the floored magnitude is never zero
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (r_s1_mag[i]) begin
                w_pos = LZ_W'(i);
            end
        end
        n_lz = LZ_W'(SAMPLE_BITS - 1) - w_pos;
    end

    assign w_norm  = r_s2_mag << r_s2_lz;
    assign n_neg   = {r_s3_lz, {FRAC_BITS{1'b0}}} - NEG_W'(w_frac_tab[r_s3_idx]);
    assign w_round = {1'b0, r_s5_prod} + ROUND_ADD;
    assign w_u     = w_round[PROD_W:24];
    assign n_db    = (w_u > U_W'(DB_FLOOR_MAG)) ? DB_FLOOR_MAG : w_u[DB_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mag  <= n_mag;
            r_s1_last <= i_last;
            r_s2_mag  <= r_s1_mag;
            r_s2_lz   <= n_lz;
            r_s2_last <= r_s1_last;
            r_s3_lz   <= r_s2_lz;
            r_s3_idx  <= w_norm[SAMPLE_BITS-2 -: LOG_TABLE_BITS];
            r_s3_last <= r_s2_last;
            r_s4_neg  <= n_neg;
            r_s4_last <= r_s3_last;
            r_s5_prod <= PROD_W'(r_s4_neg) * PROD_W'(DB_SCALE_Q16);
            r_s5_last <= r_s4_last;
            r_s6_db   <= n_db;
            r_s6_last <= r_s5_last;
        end
    end

    assign o_valid = r_s6_v;
    assign o_db    = r_s6_db;
    assign o_last  = r_s6_last;

endmodule

// ----- rtl/core/skgc_div.sv -----
// Pipelined restoring divider for the knee region, one quotient bit per stage.
module skgc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [skgc_pkg::NUM_W-1:0]      i_num,
    input  logic [skgc_pkg::KNEE_W-1:0]     i_den,
    input  skgc_pkg::t_gain_side            i_side,
    output logic                            o_valid,
    output logic [skgc_pkg::QUO_W-1:0]      o_quo,
    output skgc_pkg::t_gain_side            o_side
);
    import skgc_pkg::*;

    logic              r_v    [QUO_W];
    logic [KNEE_W-1:0] r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_low  [QUO_W];
    logic [QUO_W-1:0]  r_quo  [QUO_W];
    t_gain_side        r_side [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic              w_v_in;
        logic [KNEE_W-1:0] w_rem_in;
        logic [QUO_W-1:0]  w_low_in;
        logic [QUO_W-1:0]  w_quo_in;
        t_gain_side        w_side_in;
        logic [KNEE_W:0]   w_trial;
        logic [KNEE_W:0]   w_diff;
        logic              w_ge;

        if (s == 0) begin : g_first
            // The quotient fits QUO_W bits, so the top bits start below the divisor
            assign w_v_in    = i_valid;
            assign w_rem_in  = i_num[NUM_W-1:QUO_W];
            assign w_low_in  = i_num[QUO_W-1:0];
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_low_in  = r_low[s-1];
            assign w_quo_in  = r_quo[s-1];
            assign w_side_in = r_side[s-1];
        end

        assign w_trial = {w_rem_in, w_low_in[QUO_W-1]};
        assign w_diff  = w_trial - {1'b0, i_den};
        assign w_ge    = ~w_diff[KNEE_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? w_diff[KNEE_W-1:0] : w_trial[KNEE_W-1:0];
                r_low[s]  <= {w_low_in[QUO_W-2:0], 1'b0};
                r_quo[s]  <= {w_quo_in[QUO_W-2:0], w_ge};
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

// ----- rtl/core/soft_knee_gain_computer_unit.sv -----
// Soft-knee compressor gain computer: sample level in dB to gain change in Q7.8 dB.
//
// Input channel: i_sample (signed Q1.x) and i_last_sample, taken when i_valid is high
// and o_stall is low. Output channel: o_gain_db (Q7.8 dB, zero or negative for a
// normal slope) and o_last_gain, taken when o_valid is high and i_stall is low.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_index
// (0 threshold, 1 slope, 2 knee width); other indexes are ignored. Write only
// while the pipeline is empty.
// Throughput: one sample per cycle while o_stall is low. Latency: a sample passes through
// six level-detector stages, four gain stages, a 13-stage divider for the knee region
// and the output register before o_valid rises; every sample takes the same path.
// Reset: clears all valid bits and reloads -20 dB threshold, slope -0.5, 6 dB knee.
// Receiver stall: the output register holds its beat and one more beat lands in a
// skid register; only then does o_stall rise and the whole pipeline freeze. o_stall
// is registered, with no path from i_stall. Nothing is dropped or repeated.
module soft_knee_gain_computer_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                i_last_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [skgc_pkg::GAIN_W-1:0]  o_gain_db,
    output logic                                o_last_gain,
    input  logic                                i_cfg_we,
    input  logic [skgc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skgc_pkg::CFG_W-1:0]          i_cfg_data
);
    import skgc_pkg::*;

    localparam int OV_W = 19;

    // Configuration
    logic [THR_W-1:0]   r_threshold_db;
    logic [SLOPE_W-1:0] r_gain_slope;
    logic [KNEE_W-1:0]  r_knee_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_db <= THR_RESET;
            r_gain_slope   <= SLOPE_RESET;
            r_knee_width   <= KNEE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold_db <= i_cfg_data[THR_W-1:0];
                CFG_SLOPE:     r_gain_slope   <= i_cfg_data[SLOPE_W-1:0];
                CFG_KNEE:      r_knee_width   <= i_cfg_data[KNEE_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_v, r_skid_v;

    assign w_en    = ~r_skid_v;
    assign o_stall = r_skid_v;

    // Level in dB
    logic            w_lg_valid;
    logic [DB_W-1:0] w_lg_db;
    logic            w_lg_last;

    skgc_log #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .i_last   (i_last_sample),
        .o_valid  (w_lg_valid),
        .o_db     (w_lg_db),
        .o_last   (w_lg_last)
    );

    // Stage T1: overshoot and region select
    logic [OV_W-1:0]  w_ov, w_two_ov, w_knee_ext, w_a, w_b;
    logic             n_zero, n_knee;
    logic [OPA_W-1:0] n_opa;

    always_comb begin
        w_ov       = OV_W'(0) - {{(OV_W - DB_W){1'b0}}, w_lg_db}
                     - {{(OV_W - THR_W){r_threshold_db[THR_W-1]}}, r_threshold_db};
        w_two_ov   = {w_ov[OV_W-2:0], 1'b0};
        w_knee_ext = {{(OV_W - KNEE_W){1'b0}}, r_knee_width};
        w_a        = w_two_ov + w_knee_ext;
        w_b        = w_two_ov - w_knee_ext;
        n_zero     = w_a[OV_W-1] | (w_a == '0);
        n_knee     = ~n_zero & (w_b[OV_W-1] | (w_b == '0));
        // In the knee the term is at most twice the knee, above it the overshoot
        n_opa      = n_knee ? w_a[OPA_W-1:0] : w_ov[OPA_W-1:0];
    end

    logic             r_t1_v, r_t2_v, r_t3_v, r_t4_v;
    logic             r_t1_zero, r_t2_zero, r_t3_zero;
    logic             r_t1_knee, r_t2_knee, r_t3_knee;
    logic             r_t1_last, r_t2_last, r_t3_last;
    logic [OPA_W-1:0] r_t1_opa;
    logic [SQ_W-1:0]  r_t2_sq;
    logic [GPROD_W-1:0] r_t3_prod;
    logic             r_t3_neg;
    logic [NUM_W-1:0] r_t4_num;
    t_gain_side       r_t4_side;

    // Stage T2: square the knee term, or pass the overshoot through
    logic [OPA_W-2:0] w_kt;
    logic [SQ_W-1:0]  n_sq;

    assign w_kt = r_t1_opa[OPA_W-2:0];
    assign n_sq = r_t1_knee ? (SQ_W'(w_kt) * SQ_W'(w_kt)) : SQ_W'(r_t1_opa);

    // Stage T3: scale by the slope magnitude
    logic [SLOPE_W-1:0] w_slope_mag;

    assign w_slope_mag = r_gain_slope[SLOPE_W-1] ? (SLOPE_W'(0) - r_gain_slope) : r_gain_slope;

    // Stage T4: rounding offsets for both regions
    logic [GPROD_W:0] w_num_sum, w_lin_sum;
    t_gain_side       n_side;

    always_comb begin
        w_num_sum    = {1'b0, r_t3_prod} + ((GPROD_W + 1)'(r_knee_width) << 17);
        w_lin_sum    = {1'b0, r_t3_prod} + ((GPROD_W + 1)'(1) << 14);
        n_side.last  = r_t3_last;
        n_side.zero  = r_t3_zero;
        n_side.knee  = r_t3_knee;
        n_side.neg   = r_t3_neg;
        n_side.lin_q = w_lin_sum[15 + LIN_W - 1:15];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
        end else if (w_en) begin
            r_t1_v <= w_lg_valid;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v;
            r_t4_v <= r_t3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_zero <= n_zero;
            r_t1_knee <= n_knee;
            r_t1_opa  <= n_opa;
            r_t1_last <= w_lg_last;
            r_t2_zero <= r_t1_zero;
            r_t2_knee <= r_t1_knee;
            r_t2_sq   <= n_sq;
            r_t2_last <= r_t1_last;
            r_t3_zero <= r_t2_zero;
            r_t3_knee <= r_t2_knee;
            r_t3_prod <= GPROD_W'(w_slope_mag) * GPROD_W'(r_t2_sq);
            r_t3_neg  <= r_gain_slope[SLOPE_W-1];
            r_t3_last <= r_t2_last;
            r_t4_num  <= w_num_sum[18 + NUM_W - 1:18];
            r_t4_side <= n_side;
        end
    end

    // Knee region divides by the knee width; the other regions ride along
    logic             w_dv_valid;
    logic [QUO_W-1:0] w_dv_quo;
    t_gain_side       w_dv_side;

    skgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_t4_v),
        .i_num   (r_t4_num),
        .i_den   (r_knee_width),
        .i_side  (r_t4_side),
        .o_valid (w_dv_valid),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // Final select and sign; both regions stay well inside the gain range
    logic [GAIN_W-1:0] w_gain_mag, w_gain;

    always_comb begin
        if (w_dv_side.zero) begin
            w_gain_mag = '0;
        end else if (w_dv_side.knee) begin
            w_gain_mag = GAIN_W'(w_dv_quo);
        end else begin
            w_gain_mag = GAIN_W'(w_dv_side.lin_q);
        end
        w_gain = w_dv_side.neg ? (GAIN_W'(0) - w_gain_mag) : w_gain_mag;
    end

    // Output register with one skid entry
    logic [GAIN_W-1:0] r_out_gain, r_skid_gain;
    logic              r_out_last, r_skid_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // drain the skid beat into the output register
            if (!i_stall) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (r_out_v && i_stall) begin
            if (w_dv_valid) begin
                r_skid_v <= 1'b1;
            end
        end else begin
            r_out_v <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_stall) begin
                r_out_gain <= r_skid_gain;
                r_out_last <= r_skid_last;
            end
        end else if (r_out_v && i_stall) begin
            r_skid_gain <= w_gain;
            r_skid_last <= w_dv_side.last;
        end else begin
            r_out_gain <= w_gain;
            r_out_last <= w_dv_side.last;
        end
    end

    assign o_valid     = r_out_v;
    assign o_gain_db   = r_out_gain;
    assign o_last_gain = r_out_last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output beat");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid entry filled while the output was free");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (r_out_v && !r_skid_v))
        else $error("skid beat not moved to the output");

endmodule

// ----- dv/soft_knee_gain_computer_unit_tb.sv -----
// Self-checking bench for the soft-knee gain computer: bursty samples, output stalls, register sweeps.
module soft_knee_gain_computer_unit_tb;
    import skgc_pkg::*;

    localparam int     SAMPLE_W        = 24;
    localparam int     TABLE_BITS      = 6;
    localparam longint FULL_SCALE      = 64'sd1 <<< (SAMPLE_W - 1);
    localparam longint LEVEL_FLOOR     = (FULL_SCALE + 500000) / 1000000;
    localparam longint DB_PER_LOG2_Q16 = 394566;
    localparam longint DB_MIN_Q8       = -25600;
    localparam int     ITEMS_PER_PHASE = 83;
    localparam int     PHASES          = 10;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     REPORT_LINES    = 50;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // hard knee, limiter, widest knee, tiny knee, field extremes (one with a positive slope), steep slope
    localparam int FIXED_SETTINGS = 7;
    localparam int FIXED_THR[FIXED_SETTINGS]   = '{-5120, -2560, 0, -15360, -16384, 16383, -7680};
    localparam int FIXED_SLOPE[FIXED_SETTINGS] = '{-16384, -32768, -1, -24576, 32767, 0, -30000};
    localparam int FIXED_KNEE[FIXED_SETTINGS]  = '{0, 6144, 8191, 1, 4096, 3000, 2048};

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    typedef struct {
        logic signed [GAIN_W-1:0] gain;
        logic                     last;
    } t_gain_beat;

    class gain_checker;
        logic signed [THR_W-1:0]   threshold;
        logic signed [SLOPE_W-1:0] slope;
        logic [KNEE_W-1:0]         knee;
        longint                    frac_q16[0:(1 << TABLE_BITS) - 1];
        t_gain_beat                expected_gains[$];
        int                        errors;

        function new();
            longint unsigned x;
            threshold = -15'sd5120;
            slope     = -16'sd16384;
            knee      = 13'd1536;
            errors    = 0;
            // log2(1 + i/2^T) in Q.16, one bit per squaring step, truncated
            for (int i = 0; i < (1 << TABLE_BITS); i++) begin
                x = (64'd1 << 30) + (64'(i) << (30 - TABLE_BITS));
                frac_q16[i] = 0;
                for (int k = 15; k >= 0; k--) begin
                    x = (x * x) >> 30;
                    if (x >= (64'd2 << 30)) begin
                        x = x >> 1;
                        frac_q16[i] += 64'sd1 <<< k;
                    end
                end
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: threshold = data[THR_W-1:0];
                CFG_SLOPE:     slope     = data[SLOPE_W-1:0];
                CFG_KNEE:      knee      = data[KNEE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint level_db(logic signed [SAMPLE_W-1:0] sample);
            longint unsigned mag, rem, idx;
            longint          l2, db;
            int              p;
            mag = (sample < 0) ? -longint'(sample) : longint'(sample);
            if (mag < LEVEL_FLOOR)
                mag = LEVEL_FLOOR;
            p = SAMPLE_W - 1;
            while (p > 0 && mag[p] == 1'b0)
                p--;
            rem = mag - (64'd1 << p);
            idx = (p >= TABLE_BITS) ? rem >> (p - TABLE_BITS) : rem << (TABLE_BITS - p);
            idx = idx & ((64'd1 << TABLE_BITS) - 1);
            l2  = longint'(p - (SAMPLE_W - 1)) * 65536 + frac_q16[idx];
            // l2 is never positive; round the magnitude half up
            db  = -((-l2 * DB_PER_LOG2_Q16 + (64'sd1 <<< 23)) >>> 24);
            if (db < DB_MIN_Q8)
                db = DB_MIN_Q8;
            return db;
        endfunction

        function longint div_round(longint num, longint den);
            longint q;
            q = (((num < 0) ? -num : num) + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function t_gain_beat gain_for(logic signed [SAMPLE_W-1:0] sample, logic last);
            longint     ov, k, a, g;
            t_gain_beat beat;
            ov = level_db(sample) - longint'(threshold);
            k  = longint'(knee);
            if (2 * ov <= -k) begin
                g = 0;
            end else if (2 * ov <= k) begin
                a = 2 * ov + k;
                g = div_round(longint'(slope) * a * a, k * 8 * 32768);
            end else begin
                g = div_round(longint'(slope) * ov, 32768);
            end
            if (g < -32768)
                g = -32768;
            if (g > 32767)
                g = 32767;
            beat.gain = g[GAIN_W-1:0];
            beat.last = last;
            return beat;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] sample, logic last);
            expected_gains.push_back(gain_for(sample, last));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_LINES)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(logic signed [GAIN_W-1:0] gain, logic last);
            t_gain_beat want;
            if (expected_gains.size() == 0) begin
                report($sformatf("gain beat %0d with nothing outstanding", gain));
                return;
            end
            want = expected_gains.pop_front();
            if (gain !== want.gain)
                report($sformatf("gain_db %0d, want %0d", gain, want.gain));
            if (last !== want.last)
                report($sformatf("last_gain %b, want %b", last, want.last));
        endtask

        function int pending();
            return expected_gains.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        i_last_sample;
    logic                        o_valid;
    logic                        i_stall;
    logic signed [GAIN_W-1:0]    o_gain_db;
    logic                        o_last_gain;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_W-1:0]            i_cfg_data;

    gain_checker gains = new();
    int          accepted_samples = 0;
    int          idle_cycles = 0;

    soft_knee_gain_computer_unit #(
        .SAMPLE_BITS    (SAMPLE_W),
        .LOG_TABLE_BITS (TABLE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_gain_db     (o_gain_db),
        .o_last_gain   (o_last_gain),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                gains.note_sample(i_sample, i_last_sample);
                accepted_samples <= accepted_samples + 1;
            end
            if (o_valid && !i_stall)
                gains.check_result(o_gain_db, o_last_gain);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // receiver backpressure, switching to a new random pattern after each random span
    initial begin
        t_stall_mode mode;
        int          span;
        i_stall = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:    i_stall <= 1'b0;
                    STALL_LIGHT:   i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:   i_stall <= ($urandom_range(0, 9) < 7);
                    default:       i_stall <= ((c % 12) < 7);
                endcase
            end
        end
    end

    // call at a falling edge; hold the beat until it is taken
    task automatic send_beat(input logic signed [SAMPLE_W-1:0] sample, input logic last);
        int target;
        i_valid       <= 1'b1;
        i_sample      <= sample;
        i_last_sample <= last;
        target = accepted_samples + 1;
        do @(negedge i_clk); while (accepted_samples != target);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gains.set_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input int thr, input int slope, input int knee);
        write_register(CFG_THRESHOLD, CFG_W'(thr));
        write_register(CFG_SLOPE, CFG_W'(slope));
        write_register(CFG_KNEE, CFG_W'(knee));
    endtask

    task automatic wait_drained();
        while (gains.pending() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int unsigned m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SAMPLE_W'($urandom);
            4, 5, 6, 7: begin
                // spread the level evenly in dB
                m = $urandom_range(0, 8388607) >> $urandom_range(0, 23);
                return ($urandom_range(0, 1) != 0) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
            end
            8: begin
                case ($urandom_range(0, 3))
                    0:       return {1'b1, {(SAMPLE_W - 1){1'b0}}};
                    1:       return {1'b0, {(SAMPLE_W - 1){1'b1}}};
                    2:       return {SAMPLE_W{1'b1}};
                    default: return '0;
                endcase
            end
            default: return SAMPLE_W'($urandom_range(0, 31) - 16);
        endcase
    endfunction

    task automatic stream_random(input int count);
        int burst_left, gap;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            send_beat(random_sample(), $urandom_range(0, 7) == 0);
            burst_left--;
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        // zero, floor edges, full scale both ways, threshold and knee edges at reset settings
        logic signed [SAMPLE_W-1:0] directed[] = '{
            0, 1, -1, 7, 8, 9, 63, 64, 8388607, -8388608, -8388607,
            4194304, -4194304, 838861, 1184935, 593844, 1000000, -2000000
        };
        int thr, slope, knee;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_last_sample = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_THRESHOLD;
        i_cfg_data    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i])
            send_beat(directed[i], (i % 3) == 2);
        i_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph < FIXED_SETTINGS) begin
                apply_setting(FIXED_THR[ph], FIXED_SLOPE[ph], FIXED_KNEE[ph]);
            end else begin
                thr   = -int'($urandom_range(0, 15360));
                slope = -int'($urandom_range(0, 32768));
                knee  = $urandom_range(0, 6144);
                if ($urandom_range(0, 3) == 0)
                    slope = $urandom;
                apply_setting(thr, slope, knee);
            end
            // writes to the unused index must leave every register alone
            if (ph == 3)
                write_register(CFG_SPARE, CFG_W'($urandom));
            stream_random(ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (gains.pending() != 0)
            gains.report($sformatf("%0d gain beats never arrived", gains.pending()));
        if (gains.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
